// File: design/tbsp_pkg.sv
`timescale 1ns / 1ps

package tbsp_pkg;

  // Saturation widths of the running counters
  localparam int COUNT_WIDTH  = 16;
  localparam int UNUSED_WIDTH = 32;

  // Result event codes
  localparam logic [2:0] EV_NAME    = 3'd0;
  localparam logic [2:0] EV_PAYLOAD = 3'd1;
  localparam logic [2:0] EV_BLOCK   = 3'd2;
  localparam logic [2:0] EV_STOP    = 3'd3;
  localparam logic [2:0] EV_SUMMARY = 3'd4;

  // One result request
  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  byte_value;
    logic [3:0]  name_index;
    logic [2:0]  block_type;
    logic [15:0] data_length;
    logic [15:0] param_one;
    logic [15:0] param_two;
    logic [15:0] block_count;
    logic [31:0] unused_bytes;
    logic        file_valid;
    logic        last;
  } res_t;

  // Up to two results produced by one accepted request
  typedef struct packed {
    res_t       res0;
    res_t       res1;
    logic [1:0] num;
  } gen_t;

endpackage

// File: design/tbsp_core.sv
`timescale 1ns / 1ps

module tbsp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                func,
  input  logic [7:0]          byte_in,
  output tbsp_pkg::gen_t      gen
);

  // Parser phases
  localparam logic [3:0] PH_LEN_LO   = 4'd0;
  localparam logic [3:0] PH_LEN_HI   = 4'd1;
  localparam logic [3:0] PH_H_FLAG   = 4'd2;
  localparam logic [3:0] PH_H_TYPE   = 4'd3;
  localparam logic [3:0] PH_H_NAME   = 4'd4;
  localparam logic [3:0] PH_H_FIELDS = 4'd5;
  localparam logic [3:0] PH_H_SUM    = 4'd6;
  localparam logic [3:0] PH_D_LEN_LO = 4'd7;
  localparam logic [3:0] PH_D_LEN_HI = 4'd8;
  localparam logic [3:0] PH_D_FLAG   = 4'd9;
  localparam logic [3:0] PH_BODY     = 4'd10;
  localparam logic [3:0] PH_SUM      = 4'd11;

  logic [3:0]                        phase_r, phase_nxt;
  logic [16:0]                       cnt_r, cnt_nxt;
  logic [7:0]                        xor_r, xor_nxt;
  logic [15:0]                       blen_r, blen_nxt;
  logic [2:0]                        htype_r, htype_nxt;
  logic [15:0]                       hdlen_r, hdlen_nxt;
  logic [15:0]                       hp1_r, hp1_nxt;
  logic [15:0]                       hp2_r, hp2_nxt;
  logic [tbsp_pkg::COUNT_WIDTH-1:0]  acc_r, acc_nxt;
  logic [tbsp_pkg::UNUSED_WIDTH-1:0] unused_r, unused_nxt;
  logic                              stopped_r, stopped_nxt;

  tbsp_pkg::res_t stop_res, sum_res, zero_res;
  logic [15:0]    full_len, hl_dlen;
  logic [16:0]    body_cnt;
  logic [tbsp_pkg::COUNT_WIDTH-1:0] acc_inc;

  // Canned result records
  always_comb begin
    zero_res = '0;
    stop_res = '0;
    stop_res.event_res   = tbsp_pkg::EV_STOP;
    stop_res.block_count = 16'(acc_r);
    stop_res.file_valid  = (acc_r != '0);
    stop_res.last        = 1'b1;
    sum_res = '0;
    sum_res.event_res    = tbsp_pkg::EV_SUMMARY;
    sum_res.block_count  = 16'(acc_r);
    sum_res.unused_bytes = 32'(unused_r);
    sum_res.file_valid   = (acc_r != '0);
    sum_res.last         = 1'b1;
  end

  assign full_len = {byte_in, blen_r[7:0]};
  assign hl_dlen  = full_len - 16'd2;
  assign body_cnt = (cnt_r != '0) ? cnt_r - 17'd1 : cnt_r;
  assign acc_inc  = (acc_r != '1) ? acc_r + 1'b1 : acc_r;

  // Per-byte state update and result generation
  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    xor_nxt     = xor_r;
    blen_nxt    = blen_r;
    htype_nxt   = htype_r;
    hdlen_nxt   = hdlen_r;
    hp1_nxt     = hp1_r;
    hp2_nxt     = hp2_r;
    acc_nxt     = acc_r;
    unused_nxt  = unused_r;
    stopped_nxt = stopped_r;
    gen.res0    = zero_res;
    gen.res1    = zero_res;
    gen.num     = 2'd0;

    if (accept) begin
      if (func) begin
        // End of stream: optional stop, then summary, then fresh state
        if (!stopped_r && phase_r != PH_LEN_LO) begin
          gen.res0      = stop_res;
          gen.res0.last = 1'b0;
          gen.res1      = sum_res;
          gen.num       = 2'd2;
        end else begin
          gen.res0 = sum_res;
          gen.num  = 2'd1;
        end
        phase_nxt   = PH_LEN_LO;
        cnt_nxt     = '0;
        xor_nxt     = '0;
        blen_nxt    = '0;
        htype_nxt   = '0;
        hdlen_nxt   = '0;
        hp1_nxt     = '0;
        hp2_nxt     = '0;
        acc_nxt     = '0;
        unused_nxt  = '0;
        stopped_nxt = 1'b0;
      end else if (stopped_r) begin
        if (unused_r != '1) unused_nxt = unused_r + 1'b1;
      end else begin
        unique case (phase_r)
          PH_LEN_LO: begin
            blen_nxt  = {8'd0, byte_in};
            phase_nxt = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            blen_nxt = full_len;
            xor_nxt  = '0;
            if (full_len == 16'd19) begin
              phase_nxt = PH_H_FLAG;
            end else if (full_len == 16'd0) begin
              gen.res0    = stop_res;
              gen.num     = 2'd1;
              stopped_nxt = 1'b1;
            end else begin
              // Headerless block
              htype_nxt = 3'd4;
              hdlen_nxt = hl_dlen;
              hp1_nxt   = '0;
              hp2_nxt   = '0;
              cnt_nxt   = {1'b0, hl_dlen} + 17'd1;
              phase_nxt = PH_BODY;
            end
          end
          PH_H_FLAG: begin
            xor_nxt = xor_r ^ byte_in;
            if (byte_in != 8'd0) begin
              gen.res0    = stop_res;
              gen.num     = 2'd1;
              stopped_nxt = 1'b1;
            end else begin
              phase_nxt = PH_H_TYPE;
            end
          end
          PH_H_TYPE: begin
            xor_nxt = xor_r ^ byte_in;
            if (byte_in >= 8'd4) begin
              gen.res0    = stop_res;
              gen.num     = 2'd1;
              stopped_nxt = 1'b1;
            end else begin
              htype_nxt = byte_in[2:0];
              cnt_nxt   = '0;
              phase_nxt = PH_H_NAME;
            end
          end
          PH_H_NAME: begin
            xor_nxt              = xor_r ^ byte_in;
            gen.res0.event_res   = tbsp_pkg::EV_NAME;
            gen.res0.byte_value  = byte_in;
            gen.res0.name_index  = cnt_r[3:0];
            gen.res0.last        = 1'b1;
            gen.num              = 2'd1;
            if (cnt_r >= 17'd9) begin
              cnt_nxt   = '0;
              phase_nxt = PH_H_FIELDS;
            end else begin
              cnt_nxt = cnt_r + 17'd1;
            end
          end
          PH_H_FIELDS: begin
            xor_nxt = xor_r ^ byte_in;
            unique case (cnt_r)
              17'd0:   hdlen_nxt = {8'd0, byte_in};
              17'd1:   hdlen_nxt = {byte_in, hdlen_r[7:0]};
              17'd2:   hp1_nxt   = {8'd0, byte_in};
              17'd3:   hp1_nxt   = {byte_in, hp1_r[7:0]};
              17'd4:   hp2_nxt   = {8'd0, byte_in};
              default: hp2_nxt   = {byte_in, hp2_r[7:0]};
            endcase
            if (cnt_r >= 17'd5) begin
              cnt_nxt   = '0;
              phase_nxt = PH_H_SUM;
            end else begin
              cnt_nxt = cnt_r + 17'd1;
            end
          end
          PH_H_SUM: begin
            if (byte_in != xor_r) begin
              gen.res0    = stop_res;
              gen.num     = 2'd1;
              stopped_nxt = 1'b1;
            end else begin
              phase_nxt = PH_D_LEN_LO;
            end
          end
          PH_D_LEN_LO: begin
            blen_nxt  = {8'd0, byte_in};
            phase_nxt = PH_D_LEN_HI;
          end
          PH_D_LEN_HI: begin
            blen_nxt = full_len;
            xor_nxt  = '0;
            // Compared without wrap
            if ({1'b0, full_len} != {1'b0, hdlen_r} + 17'd2) begin
              gen.res0    = stop_res;
              gen.num     = 2'd1;
              stopped_nxt = 1'b1;
            end else begin
              phase_nxt = PH_D_FLAG;
            end
          end
          PH_D_FLAG: begin
            xor_nxt = xor_r ^ byte_in;
            if (byte_in != 8'hff) begin
              gen.res0    = stop_res;
              gen.num     = 2'd1;
              stopped_nxt = 1'b1;
            end else begin
              cnt_nxt   = {1'b0, hdlen_r};
              phase_nxt = (hdlen_r != '0) ? PH_BODY : PH_SUM;
            end
          end
          PH_BODY: begin
            xor_nxt             = xor_r ^ byte_in;
            gen.res0.event_res  = tbsp_pkg::EV_PAYLOAD;
            gen.res0.byte_value = byte_in;
            gen.res0.last       = 1'b1;
            gen.num             = 2'd1;
            cnt_nxt             = body_cnt;
            if (body_cnt == '0) phase_nxt = PH_SUM;
          end
          PH_SUM: begin
            if (byte_in != xor_r) begin
              gen.res0    = stop_res;
              gen.num     = 2'd1;
              stopped_nxt = 1'b1;
            end else begin
              acc_nxt              = acc_inc;
              gen.res0.event_res   = tbsp_pkg::EV_BLOCK;
              gen.res0.block_type  = htype_r;
              gen.res0.data_length = hdlen_r;
              gen.res0.param_one   = hp1_r;
              gen.res0.param_two   = hp2_r;
              gen.res0.block_count = 16'(acc_inc);
              gen.res0.file_valid  = 1'b1;
              gen.res0.last        = 1'b1;
              gen.num              = 2'd1;
              phase_nxt            = PH_LEN_LO;
            end
          end
          default: phase_nxt = PH_LEN_LO;
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LEN_LO;
      cnt_r     <= '0;
      xor_r     <= '0;
      blen_r    <= '0;
      htype_r   <= '0;
      hdlen_r   <= '0;
      hp1_r     <= '0;
      hp2_r     <= '0;
      acc_r     <= '0;
      unused_r  <= '0;
      stopped_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      xor_r     <= xor_nxt;
      blen_r    <= blen_nxt;
      htype_r   <= htype_nxt;
      hdlen_r   <= hdlen_nxt;
      hp1_r     <= hp1_nxt;
      hp2_r     <= hp2_nxt;
      acc_r     <= acc_nxt;
      unused_r  <= unused_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

// File: design/tbsp_outq.sv
`timescale 1ns / 1ps

module tbsp_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  tbsp_pkg::gen_t      gen,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output tbsp_pkg::res_t      out_res
);

  tbsp_pkg::res_t q0_r, q1_r, q2_r;
  tbsp_pkg::res_t q0_nxt, q1_nxt, q2_nxt;
  logic [1:0] count_r, count_nxt, rem;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign rem       = count_r - {1'b0, pop};
  assign count_nxt = rem + gen.num;
  assign out_valid = (count_r != 2'd0);
  assign out_res   = q0_r;
  // Room for a two-result request without looking at the consumer
  assign room      = (count_r <= 2'd1);

  // Shift out the popped head, append new results behind what remains
  always_comb begin
    q0_nxt = (rem > 2'd0) ? (pop ? q1_r : q0_r) : gen.res0;
    q1_nxt = (rem > 2'd1) ? (pop ? q2_r : q1_r)
           : (rem == 2'd1) ? gen.res0 : gen.res1;
    q2_nxt = (rem > 2'd2) ? q2_r
           : (rem == 2'd2) ? gen.res0
           : (rem == 2'd1) ? gen.res1 : q2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
    q2_r <= q2_nxt;
  end

  // New results only arrive when there is space for the largest request
  assert property (@(posedge clk) disable iff (!rst_n)
    gen.num != 2'd0 |-> count_r <= 2'd1)
    else $error("result queue overrun");

  // Occupancy tracks pushes and pops
  assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> count_r == $past(rem + gen.num))
    else $error("queue count mismatch");

  // A stop emitted by end of stream is not the last of its request
  assert property (@(posedge clk) disable iff (!rst_n)
    gen.num == 2'd2 |-> !gen.res0.last && gen.res1.last)
    else $error("two-result request marked wrong");

endmodule

// File: design/tape_block_stream_parser.sv
`timescale 1ns / 1ps

// Tape-image block parser. One tape byte (in_tuser = 0) or an end-of-stream
// marker (in_tuser = 1) is taken per cycle while in_tready is high. A byte request
// produces at most one result, written into a three-entry output queue at the
// accepting edge behind any results still queued. An end-of-stream request inside
// an unfinished block produces a stop result followed by the summary, so it
// fills two queue entries and, with a free consumer, holds in_tready low in
// the cycle after it. in_tready depends only on queue occupancy, never
// combinationally on out_tready. Sustained rate with a free consumer: one
// input byte per clock.
module tape_block_stream_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // byte_in[7:0]
  input  logic          in_tuser,   // func[0]
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [111:0]  out_tdata,  // byte_value[7:0], name_index[11:8],
                                    // block_type[14:12], data_length[30:15],
                                    // param_one[46:31], param_two[62:47],
                                    // block_count[78:63], unused_bytes[110:79],
                                    // file_valid[111]
  output logic [2:0]    out_tuser,  // event_res[2:0]
  output logic          out_tlast
);

  tbsp_pkg::gen_t gen;
  tbsp_pkg::res_t res;
  logic           accept;

  assign accept = in_tvalid && in_tready;

  tbsp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .func    (in_tuser),
    .byte_in (in_tdata),
    .gen     (gen)
  );

  tbsp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .gen       (gen),
    .room      (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Pack the result record onto the stream
  assign out_tuser = res.event_res;
  assign out_tlast = res.last;
  assign out_tdata = {res.file_valid, res.unused_bytes, res.block_count,
                      res.param_two, res.param_one, res.data_length,
                      res.block_type, res.name_index, res.byte_value};

endmodule
